// ===== rtl/assert_macros.svh =====
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/tsit_pkg.sv =====
package tsit_pkg;
    localparam int unsigned MaxEntries  = 64;
    localparam int unsigned MaxTopicLen = 64;
    localparam logic [31:0] HashSeed    = 32'd5381;
    localparam int unsigned HashShift   = 5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_HASH_RD,
        S_HASH_CHK,
        S_CHR_CHK,
        S_STORE,
        S_RESULT
    } t_state;
endpackage

// ===== rtl/topic_string_id_table.sv =====
// Topic string interning table. Send one nonzero character per request on
// the slave side (tdata = ch, tuser = command, tlast = end of topic); zero
// characters are dropped, and a topic of MAX_TOPIC_LEN or more characters
// answers too long. The end request carries the command and yields one result
// of status and id. Characters are taken one per cycle, also while an earlier
// result still waits on the master side. An end request walks the stored
// entries in insertion order, a hash read and then a compare per entry, and
// on a hash and length hit compares the string one character per cycle; a
// new topic is written back one character per cycle (an empty one still
// passes the store step). An end request holds the slave side until its
// result leaves its final step, once the previous result has been taken.
// The table starts empty after reset; no clearing pass is needed.
`include "assert_macros.svh"
module topic_string_id_table #(
    parameter int unsigned MAX_ENTRIES   = tsit_pkg::MaxEntries,
    parameter int unsigned MAX_TOPIC_LEN = tsit_pkg::MaxTopicLen
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    input  logic       s_axis_tuser,   // [0] command
    input  logic       s_axis_tlast,   // end_of_topic
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [1:0] status, [7:2] topic_id
);
    localparam int unsigned EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned LW = $clog2(MAX_TOPIC_LEN);
    localparam int unsigned PW = $clog2(MAX_TOPIC_LEN + 1);
    localparam int unsigned AW = EW + LW;

    logic [31:0] m_hash [MAX_ENTRIES];
    logic [LW-1:0] m_len [MAX_ENTRIES];
    logic [7:0]  m_chr [2**AW];
    logic [7:0]  m_pend [MAX_TOPIC_LEN];

    tsit_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_plen, n_plen;
    logic [31:0]   r_phash, n_phash;
    logic [EW-1:0] r_idx, n_idx;
    logic [LW-1:0] r_k, n_k;
    logic          r_cmd, n_cmd;
    logic          r_oval, n_oval;
    logic [1:0]    r_ost, n_ost;
    logic [5:0]    r_oid, n_oid;

    logic [31:0]   r_hrd;
    logic [LW-1:0] r_lrd;
    logic [7:0]    r_crd, r_prd;
    logic          r_kv;
    logic [7:0]    r_odata;

    logic          w_in_acc, w_chr_acc;
    logic [AW-1:0] w_raddr, w_waddr;
    logic [LW-1:0] w_rk;
    logic [EW:0]   w_idx_next;
    logic [5:0]    w_idx6;
    logic          w_full;
    logic          w_out_free;

    assign s_axis_tready = (r_state == tsit_pkg::S_COLLECT);
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_chr_acc = w_in_acc && !s_axis_tlast && (s_axis_tdata != 8'd0);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;
    assign w_out_free = !r_oval || m_axis_tready;
    assign w_full     = (r_count >= CW'(MAX_ENTRIES));
    assign w_idx_next = {1'b0, r_idx} + 1'b1;
    assign w_idx6     = 6'(r_idx);
    assign w_rk       = (r_state == tsit_pkg::S_STORE) ? r_k + 1'b1
                      : ((n_state == tsit_pkg::S_STORE) || (r_state == tsit_pkg::S_HASH_CHK))
                        ? '0 : r_k;
    assign w_raddr    = {r_idx, w_rk};
    assign w_waddr    = {r_idx, r_k};

    always_ff @(posedge i_clk) begin
        if (w_chr_acc && (r_plen < PW'(MAX_TOPIC_LEN))) begin
            m_pend[r_plen[LW-1:0]] <= s_axis_tdata;
        end
        r_prd <= m_pend[w_rk];
        r_hrd <= m_hash[r_idx];
        r_lrd <= m_len[r_idx];
        if (r_state == tsit_pkg::S_STORE) begin
            m_chr[w_waddr] <= r_prd;
            if (r_k == '0) begin
                m_hash[r_idx] <= r_phash;
                m_len[r_idx]  <= r_plen[LW-1:0];
            end
        end
        r_crd <= m_chr[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsit_pkg::S_COLLECT;
            r_count <= '0;
            r_plen  <= '0;
            r_phash <= tsit_pkg::HashSeed;
            r_oval  <= 1'b0;
            r_idx   <= '0;
            r_k     <= '0;
            r_cmd   <= 1'b0;
            r_kv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_plen  <= n_plen;
            r_phash <= n_phash;
            r_oval  <= n_oval;
            r_idx   <= n_idx;
            r_k     <= n_k;
            r_cmd   <= n_cmd;
            r_kv    <= (n_state == tsit_pkg::S_CHR_CHK);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ost <= n_ost;
        r_oid <= n_oid;
        if ((r_state == tsit_pkg::S_RESULT) && w_out_free) begin
            r_odata <= {r_oid, r_ost};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsit_pkg::S_COLLECT: begin
                if (w_in_acc && s_axis_tlast) begin
                    if (r_plen >= PW'(MAX_TOPIC_LEN)) n_state = tsit_pkg::S_RESULT;
                    else if (r_count == '0) begin
                        n_state = s_axis_tuser ? tsit_pkg::S_STORE : tsit_pkg::S_RESULT;
                    end
                    else n_state = tsit_pkg::S_HASH_RD;
                end
            end
            tsit_pkg::S_HASH_RD: n_state = tsit_pkg::S_HASH_CHK;
            tsit_pkg::S_HASH_CHK: begin
                if ((r_hrd == r_phash) && (PW'(r_lrd) == r_plen) && (r_plen != '0)) begin
                    n_state = tsit_pkg::S_CHR_CHK;
                end else if ((r_hrd == r_phash) && (PW'(r_lrd) == r_plen)) begin
                    n_state = tsit_pkg::S_RESULT;
                end else if (w_idx_next >= (EW+1)'(r_count)) begin
                    n_state = (r_cmd && !w_full) ? tsit_pkg::S_STORE : tsit_pkg::S_RESULT;
                end else begin
                    n_state = tsit_pkg::S_HASH_RD;
                end
            end
            tsit_pkg::S_CHR_CHK: begin
                if (r_kv && (r_crd != r_prd)) begin
                    if (w_idx_next >= (EW+1)'(r_count)) begin
                        n_state = (r_cmd && !w_full) ? tsit_pkg::S_STORE
                                                     : tsit_pkg::S_RESULT;
                    end
                    else n_state = tsit_pkg::S_HASH_RD;
                end else if (r_kv && (PW'(r_k) == r_plen)) begin
                    n_state = tsit_pkg::S_RESULT;
                end
            end
            tsit_pkg::S_STORE: begin
                if (PW'(r_k) + 1'b1 >= r_plen) n_state = tsit_pkg::S_RESULT;
            end
            tsit_pkg::S_RESULT: begin
                if (w_out_free) n_state = tsit_pkg::S_COLLECT;
            end
            default: n_state = tsit_pkg::S_COLLECT;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_plen  = r_plen;
        n_phash = r_phash;
        n_oval  = r_oval && !m_axis_tready;
        n_ost   = r_ost;
        n_oid   = r_oid;
        n_idx   = r_idx;
        n_k     = r_k;
        n_cmd   = r_cmd;
        unique case (r_state)
            tsit_pkg::S_COLLECT: begin
                if (w_chr_acc && (r_plen < PW'(MAX_TOPIC_LEN))) begin
                    n_phash = (r_phash << tsit_pkg::HashShift) + r_phash
                            + {24'd0, s_axis_tdata};
                    n_plen  = r_plen + 1'b1;
                end
                if (w_in_acc && s_axis_tlast) begin
                    n_cmd = s_axis_tuser;
                    n_idx = '0;
                    n_k   = '0;
                    n_ost = (r_plen >= PW'(MAX_TOPIC_LEN)) ? tsit_pkg::ST_TOO_LONG
                                                           : tsit_pkg::ST_NOT_FOUND;
                    n_oid = '0;
                    if ((r_plen < PW'(MAX_TOPIC_LEN)) && (r_count == '0) && s_axis_tuser) begin
                        n_ost = tsit_pkg::ST_OK;
                    end
                end
            end
            tsit_pkg::S_HASH_RD: n_k = '0;
            tsit_pkg::S_HASH_CHK: begin
                if ((r_hrd == r_phash) && (PW'(r_lrd) == r_plen)) begin
                    n_k = (r_plen != '0) ? LW'(1) : '0;
                    if (r_plen == '0) begin
                        n_ost = tsit_pkg::ST_OK;
                        n_oid = w_idx6;
                    end
                end else if (w_idx_next < (EW+1)'(r_count)) begin
                    n_idx = r_idx + 1'b1;
                end else if (r_cmd) begin
                    if (w_full) begin
                        n_ost = tsit_pkg::ST_FULL;
                    end else begin
                        n_ost = tsit_pkg::ST_OK;
                        n_oid = 6'(r_count);
                        n_idx = EW'(r_count);
                        n_k   = '0;
                    end
                end
            end
            tsit_pkg::S_CHR_CHK: begin
                if (r_kv && (r_crd != r_prd)) begin
                    if (w_idx_next < (EW+1)'(r_count)) begin
                        n_idx = r_idx + 1'b1;
                    end else if (r_cmd) begin
                        if (w_full) begin
                            n_ost = tsit_pkg::ST_FULL;
                        end else begin
                            n_ost = tsit_pkg::ST_OK;
                            n_oid = 6'(r_count);
                            n_idx = EW'(r_count);
                            n_k   = '0;
                        end
                    end
                end else if (r_kv && (PW'(r_k) == r_plen)) begin
                    n_ost = tsit_pkg::ST_OK;
                    n_oid = w_idx6;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            tsit_pkg::S_STORE: begin
                n_k = r_k + 1'b1;
                if (PW'(r_k) + 1'b1 >= r_plen) n_count = r_count + 1'b1;
            end
            tsit_pkg::S_RESULT: begin
                if (w_out_free) begin
                    n_oval  = 1'b1;
                    n_plen  = '0;
                    n_phash = tsit_pkg::HashSeed;
                end
            end
            default: ;
        endcase
    end

    `ASSERT_NEVER(a_ovf, i_clk, i_rst_n, r_count > CW'(MAX_ENTRIES))
    `ASSERT_IMPL(a_hold, i_clk, i_rst_n, r_oval && !m_axis_tready |=> r_oval)
    `ASSERT_NEVER(a_busy, i_clk, i_rst_n, s_axis_tready && (r_state != tsit_pkg::S_COLLECT))
endmodule
